// ===== src/tls_pkg.sv =====
// ----------------------------------------------------------------------------
// tls_pkg
// Shared types and constants for the tunnel link supervisor: phase codes,
// configuration register indexes, field widths and the controller/datapath
// command and status bundles.
// ----------------------------------------------------------------------------
package tls_pkg;

    localparam int DATA_W   = 32;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 2;
    localparam int PHASE_W  = 3;
    localparam int SIG_W    = 8;
    localparam int SCALE_W  = 10;

    // Stream payload widths (fields packed from bit 0, padded to bytes)
    localparam int IN_DATA_W  = 144;
    localparam int IN_USER_W  = 1;
    localparam int OUT_DATA_W = 176;

    // Link phases
    localparam logic [PHASE_W-1:0] PH_BOOT        = 3'd0;
    localparam logic [PHASE_W-1:0] PH_CONNECTING  = 3'd1;
    localparam logic [PHASE_W-1:0] PH_HANDSHAKING = 3'd2;
    localparam logic [PHASE_W-1:0] PH_ONLINE      = 3'd3;
    localparam logic [PHASE_W-1:0] PH_STALLED     = 3'd4;
    localparam logic [PHASE_W-1:0] PH_LOST        = 3'd5;
    localparam logic [PHASE_W-1:0] PH_ERROR       = 3'd6;

    // Request kinds
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_POLL  = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CONNECT_TIMEOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_BACKOFF   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD   = 2'd2;

    // Configuration reset values
    localparam logic [CFG_W-1:0] CONNECT_TIMEOUT_RST = 16'd15000;
    localparam logic [CFG_W-1:0] RETRY_BACKOFF_RST   = 16'd5000;
    localparam logic [CFG_W-1:0] SAMPLE_PERIOD_RST   = 16'd500;

    // Bytes per ms to bytes per second
    localparam logic [SCALE_W-1:0] RATE_SCALE = 10'd1000;

    // Controller to datapath
    typedef struct packed {
        logic load_in;
        logic step;
        logic mul;
        logic smooth;
        logic load_out;
    } tls_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic sample_go;
        logic div_done;
    } tls_status_t;

endpackage

// ===== src/tls_div.sv =====
// ----------------------------------------------------------------------------
// tls_div
// Restoring unsigned divider, one quotient bit per cycle. A start pulse loads
// the operands; done rises after W steps and holds until the next start.
// ----------------------------------------------------------------------------
module tls_div #(
    parameter int W = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic [W-1:0] quotient,
    output logic         done
);

    localparam int CNT_W = $clog2(W);

    logic [W-1:0]     quo_reg;
    logic [W-1:0]     rem_reg;
    logic [W-1:0]     dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [W:0] rem_shift;
    logic [W:0] diff;

    // One trial subtraction per step
    assign rem_shift = {rem_reg, quo_reg[W-1]};
    assign diff      = rem_shift - {1'b0, dvs_reg};

    // Operand and partial result registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[W])
            begin
                rem_reg <= diff[W-1:0];
                quo_reg <= {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_shift[W-1:0];
                quo_reg <= {quo_reg[W-2:0], 1'b0};
            end
        end
    end

    // Step counter and handshake flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

// ===== src/tls_datapath.sv =====
// ----------------------------------------------------------------------------
// tls_datapath
// Link state registers, configuration registers, phase update logic,
// throughput sampling with two dividers, rate smoothing and the result
// register.
// ----------------------------------------------------------------------------
module tls_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tls_pkg::tls_cmd_t             cmd,
    output tls_pkg::tls_status_t          status,
    input  logic [tls_pkg::IN_DATA_W-1:0] in_data,
    input  logic [tls_pkg::IN_USER_W-1:0] in_user,
    input  logic                          cfg_we,
    input  logic [tls_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  logic [tls_pkg::CFG_W-1:0]     cfg_wdata,
    output logic [tls_pkg::OUT_DATA_W-1:0] out_data
);

    import tls_pkg::*;

    // Latched input item
    logic [IN_DATA_W-1:0] in_data_reg;
    logic                 req_reg;

    logic [DATA_W-1:0] now_ms;
    logic              keys_ok;
    logic              link_up;
    logic              start_ok;
    logic              peer_up;
    logic [DATA_W-1:0] since_hs;
    logic [DATA_W-1:0] tx_total;
    logic [DATA_W-1:0] rx_total;
    logic [SIG_W-1:0]  signal_dbm;

    // Configuration
    logic [CFG_W-1:0] timeout_reg;
    logic [CFG_W-1:0] backoff_reg;
    logic [CFG_W-1:0] period_reg;

    // Link state
    logic [PHASE_W-1:0] phase_reg,   phase_next;
    logic [DATA_W-1:0]  entered_reg, entered_next;
    logic [DATA_W-1:0]  hs_reg,      hs_next;
    logic [DATA_W-1:0]  up_reg,      up_next;
    logic [DATA_W-1:0]  ago_reg,     ago_next;
    logic [DATA_W-1:0]  txl_reg,     txl_next;
    logic [DATA_W-1:0]  rxl_reg,     rxl_next;
    logic [SIG_W-1:0]   sig_reg,     sig_next;
    logic               flag_reg,    flag_next;

    // Sampling state
    logic [DATA_W-1:0] last_sample_reg;
    logic [DATA_W-1:0] prev_tx_reg;
    logic [DATA_W-1:0] prev_rx_reg;
    logic [DATA_W-1:0] dt_reg;
    logic [DATA_W-1:0] tx_rate_reg;
    logic [DATA_W-1:0] rx_rate_reg;

    logic [DATA_W-1:0] elapsed;
    logic [DATA_W-1:0] dt;
    logic [DATA_W-1:0] dtx;
    logic [DATA_W-1:0] drx;
    logic [DATA_W+SCALE_W-1:0] tx_prod;
    logic [DATA_W+SCALE_W-1:0] rx_prod;
    logic [DATA_W-1:0] tx_q;
    logic [DATA_W-1:0] rx_q;
    logic              tx_done;
    logic              rx_done;
    logic [DATA_W-1:0] tx_sum;
    logic [DATA_W-1:0] rx_sum;

    // Input field unpacking
    assign now_ms     = in_data_reg[31:0];
    assign keys_ok    = in_data_reg[32];
    assign link_up    = in_data_reg[33];
    assign start_ok   = in_data_reg[34];
    assign peer_up    = in_data_reg[35];
    assign since_hs   = in_data_reg[67:36];
    assign tx_total   = in_data_reg[99:68];
    assign rx_total   = in_data_reg[131:100];
    assign signal_dbm = in_data_reg[139:132];

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            in_data_reg <= in_data;
            req_reg     <= in_user[0];
        end
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= CONNECT_TIMEOUT_RST;
            backoff_reg <= RETRY_BACKOFF_RST;
            period_reg  <= SAMPLE_PERIOD_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                CFG_CONNECT_TIMEOUT: timeout_reg <= cfg_wdata;
                CFG_RETRY_BACKOFF:   backoff_reg <= cfg_wdata;
                CFG_SAMPLE_PERIOD:   period_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Phase update for one item
    assign elapsed = now_ms - entered_reg;

    always_comb
    begin
        phase_next   = phase_reg;
        entered_next = entered_reg;
        hs_next      = hs_reg;
        up_next      = up_reg;
        ago_next     = ago_reg;
        txl_next     = txl_reg;
        rxl_next     = rxl_reg;
        sig_next     = sig_reg;
        flag_next    = 1'b0;
        if (req_reg == REQ_START)
        begin
            entered_next = now_ms;
            if (keys_ok)
            begin
                phase_next = PH_CONNECTING;
                flag_next  = 1'b1;
            end
            else
            begin
                phase_next = PH_ERROR;
            end
        end
        else
        begin
            unique case (phase_reg) inside
                PH_BOOT:
                begin
                    phase_next   = PH_CONNECTING;
                    entered_next = now_ms;
                end
                PH_CONNECTING:
                begin
                    if (link_up)
                    begin
                        sig_next     = signal_dbm;
                        phase_next   = start_ok ? PH_HANDSHAKING : PH_ERROR;
                        entered_next = now_ms;
                    end
                    else if (elapsed > {{(DATA_W-CFG_W){1'b0}}, timeout_reg})
                    begin
                        phase_next   = PH_LOST;
                        entered_next = now_ms;
                    end
                end
                PH_LOST:
                begin
                    if (elapsed > {{(DATA_W-CFG_W){1'b0}}, backoff_reg})
                    begin
                        phase_next   = PH_CONNECTING;
                        entered_next = now_ms;
                    end
                end
                PH_HANDSHAKING, PH_ONLINE, PH_STALLED:
                begin
                    if (peer_up)
                    begin
                        if (phase_reg != PH_ONLINE)
                        begin
                            hs_next = hs_reg + 1'b1;
                            up_next = '0;
                        end
                        ago_next     = since_hs;
                        txl_next     = tx_total;
                        rxl_next     = rx_total;
                        phase_next   = PH_ONLINE;
                        entered_next = now_ms;
                    end
                    else if (phase_reg == PH_ONLINE)
                    begin
                        phase_next   = PH_STALLED;
                        entered_next = now_ms;
                    end
                    sig_next = signal_dbm;
                    if (!link_up)
                    begin
                        phase_next   = PH_LOST;
                        entered_next = now_ms;
                    end
                end
                default: ;
            endcase
        end
    end

    // Sample decision: a zero period behaves like one
    assign dt = now_ms - last_sample_reg;
    assign status.sample_go = (req_reg == REQ_POLL) && (dt != '0)
                              && (dt >= {{(DATA_W-CFG_W){1'b0}}, period_reg});

    // Byte deltas scaled to per-second, wrapped to 32 bits
    assign dtx     = txl_reg - prev_tx_reg;
    assign drx     = rxl_reg - prev_rx_reg;
    assign tx_prod = dtx * RATE_SCALE;
    assign rx_prod = drx * RATE_SCALE;

    tls_div #(.W(DATA_W)) u_tx_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.mul),
        .dividend (tx_prod[DATA_W-1:0]),
        .divisor  (dt_reg),
        .quotient (tx_q),
        .done     (tx_done)
    );

    tls_div #(.W(DATA_W)) u_rx_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.mul),
        .dividend (rx_prod[DATA_W-1:0]),
        .divisor  (dt_reg),
        .quotient (rx_q),
        .done     (rx_done)
    );

    assign status.div_done = tx_done && rx_done;

    // (3*old + new) wrapped, then divided by 4
    assign tx_sum = {tx_rate_reg[DATA_W-2:0], 1'b0} + tx_rate_reg + tx_q;
    assign rx_sum = {rx_rate_reg[DATA_W-2:0], 1'b0} + rx_rate_reg + rx_q;

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_BOOT;
            entered_reg     <= '0;
            hs_reg          <= '0;
            up_reg          <= '0;
            ago_reg         <= '0;
            txl_reg         <= '0;
            rxl_reg         <= '0;
            sig_reg         <= '0;
            flag_reg        <= 1'b0;
            last_sample_reg <= '0;
            prev_tx_reg     <= '0;
            prev_rx_reg     <= '0;
            dt_reg          <= '0;
            tx_rate_reg     <= '0;
            rx_rate_reg     <= '0;
        end
        else
        begin
            if (cmd.step)
            begin
                phase_reg   <= phase_next;
                entered_reg <= entered_next;
                hs_reg      <= hs_next;
                up_reg      <= up_next;
                ago_reg     <= ago_next;
                txl_reg     <= txl_next;
                rxl_reg     <= rxl_next;
                sig_reg     <= sig_next;
                flag_reg    <= flag_next;
                dt_reg      <= dt;
            end
            if (cmd.mul)
            begin
                last_sample_reg <= now_ms;
                prev_tx_reg     <= txl_reg;
                prev_rx_reg     <= rxl_reg;
            end
            if (cmd.smooth)
            begin
                tx_rate_reg <= {2'b00, tx_sum[DATA_W-1:2]};
                rx_rate_reg <= {2'b00, rx_sum[DATA_W-1:2]};
                if (phase_reg == PH_ONLINE)
                begin
                    up_reg <= up_reg + dt_reg;
                end
            end
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_data <= {4'b0000, flag_reg, sig_reg, ago_reg, rx_rate_reg,
                         tx_rate_reg, up_reg, hs_reg, phase_reg};
        end
    end

endmodule

// ===== src/tls_ctrl.sv =====
// ----------------------------------------------------------------------------
// tls_ctrl
// Sequencer for one item: latch, phase update, optional rate sample through
// the dividers, smoothing, then hand-off to the output register.
// ----------------------------------------------------------------------------
module tls_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output tls_pkg::tls_cmd_t    cmd,
    input  tls_pkg::tls_status_t status
);

    import tls_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_STEP   = 3'd1;
    localparam logic [2:0] ST_MUL    = 3'd2;
    localparam logic [2:0] ST_DIV    = 3'd3;
    localparam logic [2:0] ST_SMOOTH = 3'd4;
    localparam logic [2:0] ST_DONE   = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg;

    // Commands
    assign in_ready     = (state_reg == ST_IDLE);
    assign cmd.load_in  = in_valid && in_ready;
    assign cmd.step     = (state_reg == ST_STEP);
    assign cmd.mul      = (state_reg == ST_MUL);
    assign cmd.smooth   = (state_reg == ST_SMOOTH);
    assign cmd.load_out = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (in_valid) state_next = ST_STEP;
            ST_STEP:   state_next = status.sample_go ? ST_MUL : ST_DONE;
            ST_MUL:    state_next = ST_DIV;
            ST_DIV:    if (status.div_done) state_next = ST_SMOOTH;
            ST_SMOOTH: state_next = ST_DONE;
            ST_DONE:   if (cmd.load_out) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== src/tunnel_link_supervisor.sv =====
// ----------------------------------------------------------------------------
// tunnel_link_supervisor
// Sequence: each item is latched and stepped; a poll that takes a rate sample
//   then runs the two 32-step dividers and smoothing before the result loads.
// Flow: a new item is taken only once the last one has loaded the result;
//   the next item is taken while a finished result waits on the output.
// Reset: rst_n is asynchronous, active low; it returns the link to boot,
//   clears all counters and rates and restores the register defaults.
// ----------------------------------------------------------------------------
module tunnel_link_supervisor (
    input  logic                           clk,
    input  logic                           rst_n,
    // Input items
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // now_ms[31:0], keys_ok[32], link_up[33], start_ok[34], peer_up[35],
    // since_handshake_ms[67:36], tx_total[99:68], rx_total[131:100],
    // signal_dbm[139:132], zero pad[143:140]
    input  logic [tls_pkg::IN_DATA_W-1:0]  s_tdata,
    // req_type[0]
    input  logic [tls_pkg::IN_USER_W-1:0]  s_tuser,
    // Result items
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // link_state[2:0], handshake_count[34:3], uptime_ms[66:35],
    // tx_rate[98:67], rx_rate[130:99], last_handshake_ago[162:131],
    // signal_latched[170:163], start_ok_flag[171], zero pad[175:172]
    output logic [tls_pkg::OUT_DATA_W-1:0] m_tdata,
    // Configuration writes
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [tls_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tls_pkg::CFG_W-1:0]      cfg_data
);

    import tls_pkg::*;

    tls_cmd_t    cmd;
    tls_status_t status;

    // Registers are always writable
    assign cfg_ready = 1'b1;

    tls_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .cmd       (cmd),
        .status    (status)
    );

    tls_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_data   (s_tdata),
        .in_user   (s_tuser),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_idx   (cfg_index),
        .cfg_wdata (cfg_data),
        .out_data  (m_tdata)
    );

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the tunnel link supervisor. A directed table walks
// boot, start requests with and without keys, the connect timeout, the retry
// backoff, handshakes, stalls, link loss, a zero sample period and the wrap of
// the ms clock. Random well-formed poll traffic with occasional clock jumps,
// counter jumps and start requests follows, over several register settings.
// Every result item is compared with a cycle-free model of the supervisor.
// ----------------------------------------------------------------------------
module tb_top;
    import tls_pkg::*;

    // One input item, unpacked
    typedef struct packed {
        logic              req;
        logic [31:0]       now;
        logic              keys_ok;
        logic              link_up;
        logic              start_ok;
        logic              peer_up;
        logic [31:0]       since;
        logic [31:0]       tx;
        logic [31:0]       rx;
        logic signed [7:0] sig;
    } link_req_t;

    // One result item, unpacked
    typedef struct packed {
        logic [2:0]  link_state;
        logic [31:0] hs_count;
        logic [31:0] uptime;
        logic [31:0] tx_rate;
        logic [31:0] rx_rate;
        logic [31:0] hs_ago;
        logic [7:0]  sig;
        logic        flag;
    } link_status_t;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    // Directed stimulus row; want is used only where typed is set
    typedef struct packed {
        row_kind_t    kind;
        link_req_t    item;
        logic [1:0]   cfg_idx;
        logic [15:0]  cfg_val;
        logic         typed;
        link_status_t want;
    } dir_row_t;

    localparam int DIR_ROWS = 30;
    localparam int SEGMENTS = 6;
    localparam int SEG_ITEMS = 250;
    localparam link_status_t ST_NONE = '0;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [IN_USER_W-1:0]  s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_W-1:0]      cfg_data = '0;

    // Supervisor model state
    logic [15:0] cf_timeout;
    logic [15:0] cf_backoff;
    logic [15:0] cf_period;
    logic [2:0]  lk_phase;
    logic [31:0] lk_entered;
    logic [31:0] smp_last;
    logic [31:0] base_tx;
    logic [31:0] base_rx;
    logic [31:0] held_tx;
    logic [31:0] held_rx;
    logic [31:0] tx_avg;
    logic [31:0] rx_avg;
    logic [31:0] hs_total;
    logic [31:0] online_ms;
    logic [31:0] hs_ago;
    logic [7:0]  sig_held;

    // Random traffic source state
    logic [31:0] wall_ms = '0;
    logic [31:0] tx_run = '0;
    logic [31:0] rx_run = '0;

    link_status_t pending_status[$];
    int unsigned  mismatch_cnt = 0;
    int unsigned  src_gap_pct = 7;
    int unsigned  sink_stall_pct = 75;

    tunnel_link_supervisor i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Model of the supervisor
    // ------------------------------------------------------------------
    function automatic void clear_model();
        cf_timeout = CONNECT_TIMEOUT_RST;
        cf_backoff = RETRY_BACKOFF_RST;
        cf_period  = SAMPLE_PERIOD_RST;
        lk_phase   = PH_BOOT;
        lk_entered = '0;
        smp_last   = '0;
        base_tx    = '0;
        base_rx    = '0;
        held_tx    = '0;
        held_rx    = '0;
        tx_avg     = '0;
        rx_avg     = '0;
        hs_total   = '0;
        online_ms  = '0;
        hs_ago     = '0;
        sig_held   = '0;
    endfunction

    function automatic void move_to(logic [2:0] p, logic [31:0] at);
        lk_phase   = p;
        lk_entered = at;
    endfunction

    function automatic link_status_t supervise_link(link_req_t r);
        link_status_t st;
        logic [31:0]  dt;
        logic [31:0]  dtx;
        logic [31:0]  drx;
        logic [31:0]  itx;
        logic [31:0]  irx;
        st = '0;
        if (r.req == REQ_START)
        begin
            move_to(r.keys_ok ? PH_CONNECTING : PH_ERROR, r.now);
            st.flag = r.keys_ok;
        end
        else
        begin
            case (lk_phase) inside
                PH_BOOT:
                    move_to(PH_CONNECTING, r.now);
                PH_CONNECTING:
                    if (r.link_up)
                    begin
                        sig_held = r.sig;
                        move_to(r.start_ok ? PH_HANDSHAKING : PH_ERROR, r.now);
                    end
                    else if (r.now - lk_entered > 32'(cf_timeout))
                        move_to(PH_LOST, r.now);
                PH_LOST:
                    if (r.now - lk_entered > 32'(cf_backoff))
                        move_to(PH_CONNECTING, r.now);
                PH_HANDSHAKING, PH_ONLINE, PH_STALLED:
                begin
                    if (r.peer_up)
                    begin
                        // a fresh handshake restarts the uptime
                        if (lk_phase != PH_ONLINE)
                        begin
                            hs_total  = hs_total + 32'd1;
                            online_ms = '0;
                        end
                        hs_ago  = r.since;
                        held_tx = r.tx;
                        held_rx = r.rx;
                        move_to(PH_ONLINE, r.now);
                    end
                    else if (lk_phase == PH_ONLINE)
                        move_to(PH_STALLED, r.now);
                    sig_held = r.sig;
                    if (!r.link_up)
                        move_to(PH_LOST, r.now);
                end
                default:
                    ;
            endcase

            // Rate sample; a zero period behaves like one
            dt = r.now - smp_last;
            if (dt != 32'd0 && dt >= 32'(cf_period))
            begin
                smp_last = r.now;
                dtx      = held_tx - base_tx;
                drx      = held_rx - base_rx;
                base_tx  = held_tx;
                base_rx  = held_rx;
                itx      = (dtx * 32'd1000) / dt;
                irx      = (drx * 32'd1000) / dt;
                tx_avg   = (tx_avg * 32'd3 + itx) / 32'd4;
                rx_avg   = (rx_avg * 32'd3 + irx) / 32'd4;
                if (lk_phase == PH_ONLINE)
                    online_ms = online_ms + dt;
            end
        end
        st.link_state = lk_phase;
        st.hs_count   = hs_total;
        st.uptime     = online_ms;
        st.tx_rate    = tx_avg;
        st.rx_rate    = rx_avg;
        st.hs_ago     = hs_ago;
        st.sig        = sig_held;
        return st;
    endfunction

    // ------------------------------------------------------------------
    // Item builders
    // ------------------------------------------------------------------
    function automatic link_req_t mk_poll(logic [31:0] now, logic link, logic st_ok,
                                          logic peer, logic [31:0] since,
                                          logic [31:0] tx, logic [31:0] rx,
                                          logic [7:0] sig);
        link_req_t r;
        r          = '0;
        r.req      = REQ_POLL;
        r.now      = now;
        r.link_up  = link;
        r.start_ok = st_ok;
        r.peer_up  = peer;
        r.since    = since;
        r.tx       = tx;
        r.rx       = rx;
        r.sig      = sig;
        return r;
    endfunction

    function automatic link_req_t mk_start(logic [31:0] now, logic keys);
        link_req_t r;
        r         = '0;
        r.req     = REQ_START;
        r.now     = now;
        r.keys_ok = keys;
        return r;
    endfunction

    // Mostly steady polls with growing counters; rare jumps and starts
    function automatic link_req_t next_req();
        link_req_t   r;
        int unsigned pick;
        int          dbm;
        pick = $urandom_range(99);
        if (pick < 70)
            wall_ms = wall_ms + $urandom_range(700);
        else if (pick < 90)
            wall_ms = wall_ms + $urandom_range(6000, 700);
        else if (pick < 97)
            wall_ms = wall_ms + $urandom_range(70000, 6000);
        else
            wall_ms = $urandom();
        if ($urandom_range(99) < 95)
            tx_run = tx_run + $urandom_range(200000);
        else
            tx_run = $urandom();
        if ($urandom_range(99) < 95)
            rx_run = rx_run + $urandom_range(200000);
        else
            rx_run = $urandom();
        dbm        = $urandom_range(128);
        r.req      = ($urandom_range(99) < 5) ? REQ_START : REQ_POLL;
        r.now      = wall_ms;
        r.keys_ok  = $urandom_range(99) < 80;
        r.link_up  = $urandom_range(99) < 92;
        r.start_ok = $urandom_range(99) < 90;
        r.peer_up  = $urandom_range(99) < 75;
        r.since    = ($urandom_range(99) < 90) ? $urandom_range(180000) : $urandom();
        r.tx       = tx_run;
        r.rx       = rx_run;
        r.sig      = 8'(-dbm);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Drivers; each task is entered and left just after a falling edge
    // ------------------------------------------------------------------
    task automatic send_item(link_req_t r, logic typed, link_status_t want);
        link_status_t st;
        // config channel stays quiet while items flow
        cfg_valid <= 1'b0;
        while ($urandom_range(99) < src_gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.req;
        s_tdata  <= {4'b0, r.sig, r.rx, r.tx, r.since, r.peer_up, r.start_ok,
                     r.link_up, r.keys_ok, r.now};
        do
            @(posedge clk);
        while (!s_tready);
        st = supervise_link(r);
        pending_status.push_back(typed ? want : st);
        @(negedge clk);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_status.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_CONNECT_TIMEOUT: cf_timeout = val;
            CFG_RETRY_BACKOFF:   cf_backoff = val;
            CFG_SAMPLE_PERIOD:   cf_period  = val;
            default:             ;
        endcase
        @(negedge clk);
    endtask

    // Receiver back-pressure
    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= sink_stall_pct);

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------
    function automatic void check_field(string fname, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0h got %0h", $time, fname, want, got);
            mismatch_cnt++;
        end
    endfunction

    always @(posedge clk)
    begin
        link_status_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_status.size() == 0)
            begin
                $display("%0t: result expected none got %h", $time, m_tdata);
                mismatch_cnt++;
            end
            else
            begin
                want = pending_status.pop_front();
                check_field("link_state", 32'(want.link_state), 32'(m_tdata[2:0]));
                check_field("handshake_count", want.hs_count, m_tdata[34:3]);
                check_field("uptime_ms", want.uptime, m_tdata[66:35]);
                check_field("tx_rate", want.tx_rate, m_tdata[98:67]);
                check_field("rx_rate", want.rx_rate, m_tdata[130:99]);
                check_field("last_handshake_ago", want.hs_ago, m_tdata[162:131]);
                check_field("signal_latched", 32'(want.sig), 32'(m_tdata[170:163]));
                check_field("start_ok_flag", 32'(want.flag), 32'(m_tdata[171]));
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        dir_row_t    dir_tab [DIR_ROWS];
        int unsigned seg;
        int unsigned n;

        // boot, keys, timeout and backoff edges, handshakes, zero period, ms wrap
        dir_tab = '{
            '{ROW_ITEM, mk_poll(32'd0, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0, 8'h00),
              '0, 16'd0, 1'b1, {PH_CONNECTING, 168'd0, 1'b0}},
            '{ROW_ITEM, mk_start(32'd10, 1'b0), '0, 16'd0, 1'b1, {PH_ERROR, 168'd0, 1'b0}},
            '{ROW_ITEM, mk_poll(32'd1000, 1'b1, 1'b1, 1'b1, 32'd5, 32'd777, 32'd888, 8'hD8),
              '0, 16'd0, 1'b1, {PH_ERROR, 168'd0, 1'b0}},
            '{ROW_ITEM, mk_start(32'd1100, 1'b1), '0, 16'd0, 1'b1,
              {PH_CONNECTING, 168'd0, 1'b1}},
            '{ROW_ITEM, mk_poll(32'd1200, 1'b1, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0, 8'h00),
              '0, 16'd0, 1'b1, {PH_ERROR, 168'd0, 1'b0}},
            '{ROW_ITEM, mk_start(32'd1300, 1'b1), '0, 16'd0, 1'b1,
              {PH_CONNECTING, 168'd0, 1'b1}},
            '{ROW_ITEM, mk_poll(32'd1400, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0, 8'h00),
              '0, 16'd0, 1'b1, {PH_CONNECTING, 168'd0, 1'b0}},
            '{ROW_ITEM, mk_poll(32'd16300, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0, 8'h00),
              '0, 16'd0, 1'b0, ST_NONE},
            '{ROW_ITEM, mk_poll(32'd16301, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0, 8'h00),
              '0, 16'd0, 1'b1, {PH_LOST, 168'd0, 1'b0}},
            '{ROW_ITEM, mk_poll(32'd21301, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0, 8'h00),
              '0, 16'd0, 1'b0, ST_NONE},
            '{ROW_ITEM, mk_poll(32'd21302, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0, 8'h00),
              '0, 16'd0, 1'b0, ST_NONE},
            '{ROW_ITEM, mk_poll(32'd21303, 1'b1, 1'b1, 1'b0, 32'd0, 32'd0, 32'd0, 8'h80),
              '0, 16'd0, 1'b0, ST_NONE},
            '{ROW_ITEM, mk_poll(32'd22000, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                32'h1234_5678, 8'hFF),
              '0, 16'd0, 1'b0, ST_NONE},
            '{ROW_ITEM, mk_poll(32'd22600, 1'b1, 1'b1, 1'b0, 32'd100, 32'd0, 32'd0, 8'hC0),
              '0, 16'd0, 1'b0, ST_NONE},
            '{ROW_ITEM, mk_poll(32'd23200, 1'b1, 1'b1, 1'b1, 32'd0, 32'd0, 32'hFFFF_FFFF,
                                8'h9C),
              '0, 16'd0, 1'b0, ST_NONE},
            '{ROW_ITEM, mk_poll(32'd24000, 1'b1, 1'b1, 1'b1, 32'd800, 32'd3000000, 32'd4000,
                                8'hE0),
              '0, 16'd0, 1'b0, ST_NONE},
            '{ROW_ITEM, mk_poll(32'd24700, 1'b0, 1'b1, 1'b1, 32'd1, 32'd3100000, 32'd9000,
                                8'hF0),
              '0, 16'd0, 1'b0, ST_NONE},
            '{ROW_CFG, '0, CFG_SAMPLE_PERIOD, 16'd0, 1'b0, ST_NONE},
            '{ROW_ITEM, mk_poll(32'd24700, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0, 8'h00),
              '0, 16'd0, 1'b0, ST_NONE},
            '{ROW_ITEM, mk_poll(32'd24701, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0, 8'h00),
              '0, 16'd0, 1'b0, ST_NONE},
            '{ROW_CFG, '0, CFG_CONNECT_TIMEOUT, 16'd0, 1'b0, ST_NONE},
            '{ROW_CFG, '0, CFG_RETRY_BACKOFF, 16'd0, 1'b0, ST_NONE},
            '{ROW_ITEM, mk_poll(32'd24701, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0, 8'h00),
              '0, 16'd0, 1'b0, ST_NONE},
            '{ROW_ITEM, mk_poll(32'd24702, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0, 8'h00),
              '0, 16'd0, 1'b0, ST_NONE},
            '{ROW_ITEM, mk_poll(32'd24702, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0, 8'h00),
              '0, 16'd0, 1'b0, ST_NONE},
            '{ROW_ITEM, mk_poll(32'd24703, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0, 8'h00),
              '0, 16'd0, 1'b0, ST_NONE},
            '{ROW_ITEM, mk_poll(32'hFFFF_FFF0, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0, 8'h00),
              '0, 16'd0, 1'b0, ST_NONE},
            '{ROW_ITEM, mk_poll(32'd5, 1'b1, 1'b1, 1'b0, 32'd0, 32'd0, 32'd0, 8'hA5),
              '0, 16'd0, 1'b0, ST_NONE},
            '{ROW_ITEM, mk_poll(32'd16, 1'b1, 1'b1, 1'b1, 32'd77, 32'hFFFF_FF00, 32'd100,
                                8'hFF),
              '0, 16'd0, 1'b0, ST_NONE},
            '{ROW_ITEM, mk_start(32'd32, 1'b1), '0, 16'd0, 1'b0, ST_NONE}
        };

        clear_model();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed table
        for (n = 0; n < DIR_ROWS; n++)
        begin
            if (dir_tab[n].kind == ROW_CFG)
                write_reg(dir_tab[n].cfg_idx, dir_tab[n].cfg_val);
            else
                send_item(dir_tab[n].item, dir_tab[n].typed, dir_tab[n].want);
        end

        // Random traffic, one register setting per segment
        for (seg = 0; seg < SEGMENTS; seg++)
        begin
            src_gap_pct    = (seg < 2) ? 7 : (seg < 4) ? 75 : 0;
            sink_stall_pct = (seg < 2) ? 75 : (seg < 4) ? 7 : 0;
            case (seg)
                0:
                begin
                    write_reg(CFG_CONNECT_TIMEOUT, 16'($urandom_range(3000)));
                    write_reg(CFG_RETRY_BACKOFF, 16'($urandom_range(3000)));
                    write_reg(CFG_SAMPLE_PERIOD, 16'($urandom_range(1000, 1)));
                end
                1:
                begin
                    write_reg(CFG_CONNECT_TIMEOUT, 16'hFFFF);
                    write_reg(CFG_RETRY_BACKOFF, 16'hFFFF);
                    write_reg(CFG_SAMPLE_PERIOD, 16'hFFFF);
                end
                2:
                begin
                    write_reg(CFG_CONNECT_TIMEOUT, 16'd0);
                    write_reg(CFG_RETRY_BACKOFF, 16'd0);
                    write_reg(CFG_SAMPLE_PERIOD, 16'd1);
                end
                3:
                begin
                    write_reg(CFG_CONNECT_TIMEOUT, CONNECT_TIMEOUT_RST);
                    write_reg(CFG_RETRY_BACKOFF, RETRY_BACKOFF_RST);
                    write_reg(CFG_SAMPLE_PERIOD, SAMPLE_PERIOD_RST);
                end
                4:
                begin
                    write_reg(CFG_CONNECT_TIMEOUT, 16'($urandom()));
                    write_reg(CFG_RETRY_BACKOFF, 16'($urandom()));
                    write_reg(CFG_SAMPLE_PERIOD, 16'($urandom_range(65535, 1)));
                end
                default:
                begin
                    write_reg(CFG_CONNECT_TIMEOUT, 16'($urandom_range(300)));
                    write_reg(CFG_RETRY_BACKOFF, 16'($urandom_range(300)));
                    write_reg(CFG_SAMPLE_PERIOD, 16'($urandom_range(50, 1)));
                end
            endcase
            for (n = 0; n < SEG_ITEMS; n++)
                send_item(next_req(), 1'b0, ST_NONE);
        end

        // Let the last results out, then watch for strays
        drain_results();
        repeat (50) @(negedge clk);
        if (mismatch_cnt == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    // Watchdog
    initial
    begin
        #20_000_000;
        $display("tb_top: errors");
        $finish;
    end

endmodule
